FILE: rtl/core/kmp_pkg.sv
// shared constants and types of the kmp stream matcher
`default_nettype none

package kmp_pkg;

	// pattern store depth and derived widths
	localparam int MAX_PATTERN = 256;
	localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

	// fixed payload widths
	localparam int SYM_W  = 8;
	localparam int LEN_W  = 9;
	localparam int STAT_W = 2;

	// request kinds
	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_NO_PAT = 2'd2
	} kmp_status_t;

	// one input request as seen by the datapath
	typedef struct packed {
		logic             op;
		logic             start_req;
		logic [SYM_W-1:0] symbol;
	} kmp_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic setup;
		logic rd;
		logic step;
		logic fail_rd;
		logic fail_take;
		logic emit;
	} kmp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic setup_done;
		logic step_done;
		logic step_full;
		logic out_free;
	} kmp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/kmp_if.sv
// request and result channel interfaces of the kmp stream matcher
`default_nettype none

interface kmp_in_if
	import kmp_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic             op;
	logic             start_req;
	logic [SYM_W-1:0] symbol;

	modport source (output valid, output op, output start_req, output symbol, input ready);
	modport sink (input valid, input op, input start_req, input symbol, output ready);
endinterface

interface kmp_out_if
	import kmp_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [LEN_W-1:0]  match_length;
	logic              full_match;
	logic [STAT_W-1:0] status;

	modport source (output valid, output match_length, output full_match, output status,
		input ready);
	modport sink (input valid, input match_length, input full_match, input status,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kmp_ctrl.sv
// sequencing state machine of the kmp stream matcher
`default_nettype none

module kmp_ctrl
	import kmp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire kmp_stat_t st,
	output kmp_cmd_t       cmd
);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_SETUP     = 7'b0000010,
		S_READ      = 7'b0000100,
		S_CMP       = 7'b0001000,
		S_FAIL_RD   = 7'b0010000,
		S_FAIL_TAKE = 7'b0100000,
		S_DONE      = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = st.setup_done ? S_DONE : S_READ;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.step = 1'b1;
				if (!st.step_done)
					state_d = S_READ;
				else if (st.step_full)
					state_d = S_FAIL_RD;
				else
					state_d = S_DONE;
			end
			S_FAIL_RD: begin
				cmd.fail_rd = 1'b1;
				state_d     = S_FAIL_TAKE;
			end
			S_FAIL_TAKE: begin
				cmd.fail_take = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

FILE: rtl/core/kmp_dp.sv
// pattern and failure memories, match registers and result register
`default_nettype none

module kmp_dp
	import kmp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire kmp_item_t item,
	input  wire kmp_cmd_t  cmd,
	output kmp_stat_t      st,
	kmp_out_if.source      result_out
);

	logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
	logic [CNT_W-1:0] fail_mem [MAX_PATTERN];

	logic             op_q;
	logic             start_q;
	logic [SYM_W-1:0] sym_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] bb_q;
	logic [CNT_W-1:0] tm_q;
	logic [CNT_W-1:0] j_q;
	logic [SYM_W-1:0] pat_rd_q;
	logic [CNT_W-1:0] fail_rd_q;
	logic [CNT_W-1:0] res_len_q;
	logic             res_full_q;
	kmp_status_t      res_stat_q;
	logic             out_valid_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_full_q;
	kmp_status_t      out_stat_q;

	logic [CNT_W-1:0]  eff_len;
	logic              eq;
	logic [CNT_W-1:0]  j_new;
	logic [CNT_W-1:0]  fail_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CNT_W-1:0]  wr_border;

	// pattern length after a restart request
	assign eff_len = (op_q == OP_PATTERN && start_q) ? '0 : len_q;

	// decisions for the controller
	assign st.setup_done = (op_q == OP_PATTERN) ?
		((eff_len == CNT_W'(MAX_PATTERN)) || (eff_len == '0)) : (len_q == '0);

	// one failure-chain comparison
	assign eq           = (pat_rd_q == sym_q);
	assign st.step_done = eq || (j_q == '0);
	assign j_new        = eq ? CNT_W'(j_q + CNT_W'(1)) : '0;
	assign st.step_full = (op_q == OP_TEXT) && (j_new == len_q);
	assign st.out_free  = !out_valid_q || result_out.ready;

	// failure table read address: last entry on a full match, else entry before j
	always_comb begin
		if (cmd.fail_rd)
			fail_addr = CNT_W'(len_q - CNT_W'(1));
		else if (j_q == '0)
			fail_addr = '0;
		else
			fail_addr = CNT_W'(j_q - CNT_W'(1));
	end

	// append of a pattern symbol
	assign wr_en = (op_q == OP_PATTERN) &&
		((cmd.setup && eff_len == '0) || (cmd.step && st.step_done));
	assign wr_addr   = cmd.setup ? '0 : len_q[ADDR_W-1:0];
	assign wr_border = cmd.setup ? '0 : j_new;

	// memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_mem[wr_addr]  <= sym_q;
			fail_mem[wr_addr] <= wr_border;
		end
		if (cmd.rd)
			pat_rd_q <= pat_mem[j_q[ADDR_W-1:0]];
		if (cmd.rd || cmd.fail_rd)
			fail_rd_q <= fail_mem[fail_addr[ADDR_W-1:0]];
	end

	// pattern length, build border, text match and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			bb_q        <= '0;
			tm_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.setup && op_q == OP_PATTERN) begin
				if (start_q)
					tm_q <= '0;
				// empty store after an optional restart: first symbol goes in
				if (eff_len == '0) begin
					len_q <= CNT_W'(1);
					bb_q  <= '0;
				end
			end
			if (cmd.step && st.step_done) begin
				if (op_q == OP_PATTERN) begin
					len_q <= CNT_W'(len_q + CNT_W'(1));
					bb_q  <= j_new;
				end else if (!st.step_full) begin
					tm_q <= j_new;
				end
			end
			if (cmd.fail_take)
				tm_q <= fail_rd_q;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (result_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	// request capture, walk position and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= item.op;
			start_q <= item.start_req;
			sym_q   <= item.symbol;
		end
		if (cmd.setup) begin
			res_len_q  <= '0;
			res_full_q <= 1'b0;
			if (op_q == OP_PATTERN) begin
				j_q        <= bb_q;
				res_stat_q <= (eff_len == CNT_W'(MAX_PATTERN)) ? STAT_FULL : STAT_OK;
			end else begin
				j_q        <= (start_q || tm_q >= len_q) ? '0 : tm_q;
				res_stat_q <= (len_q == '0) ? STAT_NO_PAT : STAT_OK;
			end
		end
		if (cmd.step) begin
			if (!st.step_done) begin
				j_q <= fail_rd_q;
			end else begin
				res_len_q  <= j_new;
				res_full_q <= st.step_full;
			end
		end
		if (cmd.emit) begin
			out_len_q  <= LEN_W'(res_len_q);
			out_full_q <= res_full_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.match_length = out_len_q;
	assign result_out.full_match   = out_full_q;
	assign result_out.status       = out_stat_q;

endmodule

`default_nettype wire

FILE: rtl/core/kmp_stream_matcher_top.sv
// Top level of the kmp stream matcher: one result per request.
// Sequence: capture, setup, then per compare step a memory read and a compare, and on a full
// match a read of the failure table to fetch the fallback; the result then waits for a free output register.
// A request is taken only once the previous one has been emitted into the output register;
// the next request is taken while the previous result waits in the output register.
// Reset: arst_n clears lengths, border and handshake state; memories are not cleared.
`default_nettype none

module kmp_stream_matcher_top
	import kmp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	kmp_in_if.sink    item_in,
	kmp_out_if.source result_out
);

	kmp_cmd_t  cmd;
	kmp_stat_t st;
	kmp_item_t item;
	logic      in_ready;

	assign item.op        = item_in.op;
	assign item.start_req = item_in.start_req;
	assign item.symbol    = item_in.symbol;
	assign item_in.ready  = in_ready;

	// sequencer
	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// memories and match registers
	kmp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cmd        (cmd),
		.st         (st),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

FILE: tb/kmp_match_checker.sv
`timescale 1ns / 1ps
// result checker of the kmp stream matcher: tracks requests, predicts results, compares them

module kmp_match_checker
	import kmp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	kmp_in_if         item_in,
	kmp_out_if        result_out,
	output int        fail_count,
	output int        outstanding
);

	// one predicted result
	typedef struct packed {
		logic [LEN_W-1:0] match_length;
		logic             full_match;
		kmp_status_t      status;
	} match_result_t;

	// shadow of the matcher state
	logic [SYM_W-1:0] pat_sym [MAX_PATTERN];
	logic [LEN_W-1:0] border_tab [MAX_PATTERN];
	logic [LEN_W-1:0] pat_len     = '0;
	logic [LEN_W-1:0] grow_border = '0;
	logic [LEN_W-1:0] text_len    = '0;

	match_result_t pending_results [$];
	int mismatches = 0;

	assign fail_count = mismatches;

	// applies one request to the shadow state and returns its result
	function automatic match_result_t advance_matcher(kmp_item_t req);
		match_result_t    res;
		logic [LEN_W-1:0] b;
		logic [LEN_W-1:0] j;
		res.match_length = '0;
		res.full_match   = 1'b0;
		res.status       = STAT_OK;
		if (req.op == OP_PATTERN) begin
			if (req.start_req) begin
				pat_len     = '0;
				grow_border = '0;
				text_len    = '0;
			end
			if (pat_len >= MAX_PATTERN) begin
				res.status = STAT_FULL;
			end else begin
				// border of the new prefix by walking the failure chain
				b = '0;
				if (pat_len > 0) begin
					b = grow_border;
					while (b > 0 && pat_sym[b[ADDR_W-1:0]] != req.symbol)
						b = border_tab[ADDR_W'(b - LEN_W'(1))];
					if (pat_sym[b[ADDR_W-1:0]] == req.symbol)
						b = b + LEN_W'(1);
				end
				pat_sym[pat_len[ADDR_W-1:0]]    = req.symbol;
				border_tab[pat_len[ADDR_W-1:0]] = b;
				pat_len                         = pat_len + LEN_W'(1);
				grow_border                     = b;
				res.match_length                = b;
			end
		end else if (pat_len == 0) begin
			res.status = STAT_NO_PAT;
		end else begin
			// advance the text match, fall back on mismatch
			j = req.start_req ? '0 : text_len;
			if (j >= pat_len)
				j = '0;
			while (j > 0 && pat_sym[j[ADDR_W-1:0]] != req.symbol)
				j = border_tab[ADDR_W'(j - LEN_W'(1))];
			if (j < pat_len && pat_sym[j[ADDR_W-1:0]] == req.symbol)
				j = j + LEN_W'(1);
			res.match_length = j;
			// whole occurrence: fall back to allow overlaps
			if (j == pat_len) begin
				res.full_match = 1'b1;
				j = border_tab[ADDR_W'(j - LEN_W'(1))];
			end
			text_len = j;
		end
		return res;
	endfunction

	// watch both channels, predict on request, compare on result
	always @(posedge clk or negedge arst_n) begin
		match_result_t want;
		kmp_item_t     req;
		if (!arst_n) begin
			pat_len     = '0;
			grow_border = '0;
			text_len    = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (item_in.valid && item_in.ready) begin
				req.op        = item_in.op;
				req.start_req = item_in.start_req;
				req.symbol    = item_in.symbol;
				pending_results.push_back(advance_matcher(req));
			end
			if (result_out.valid && result_out.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: match_length %0d full_match %0d status %0d",
						result_out.match_length, result_out.full_match, result_out.status);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (result_out.match_length !== want.match_length) begin
						$error("match_length: expected %0d, got %0d",
							want.match_length, result_out.match_length);
						mismatches++;
					end
					if (result_out.full_match !== want.full_match) begin
						$error("full_match: expected %0d, got %0d",
							want.full_match, result_out.full_match);
						mismatches++;
					end
					if (result_out.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_out.status);
						mismatches++;
					end
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: tb/tb_kmp_stream_matcher_top.sv
`timescale 1ns / 1ps
// testbench top of the kmp stream matcher: clock, reset, request stimulus, watchdog and verdict

module tb_kmp_stream_matcher_top;
	import kmp_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int TAIL_CYCLES     = 40;
	localparam int TARGET_REQUESTS = 1500;
	localparam int FILL_ROOM       = 700;

	localparam logic [SYM_W-1:0] SYM_A    = 8'h61;
	localparam logic [SYM_W-1:0] SYM_B    = 8'h62;
	localparam logic [SYM_W-1:0] SYM_C    = 8'h63;
	localparam logic [SYM_W-1:0] SYM_ZERO = 8'h00;
	localparam logic [SYM_W-1:0] SYM_ONES = 8'hFF;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   outstanding;
	int   idle_cycles = 0;
	int   sent        = 0;
	bit   send_calm   = 1'b0;
	bit   recv_calm   = 1'b0;

	// copy of the pattern as sent, used to build text that matches
	logic [SYM_W-1:0] pattern_copy [MAX_PATTERN];
	int               copy_len = 0;

	kmp_in_if  item_if();
	kmp_out_if result_if();

	kmp_stream_matcher_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_if),
		.result_out(result_if)
	);

	kmp_match_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (result_if),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	function automatic int draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// one request, held until accepted
	task automatic send_request(logic op, logic start, logic [SYM_W-1:0] sym);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.op        <= op;
		item_if.start_req <= start;
		item_if.symbol    <= sym;
		item_if.valid     <= 1'b1;
		do @(posedge clk); while (!(item_if.valid && item_if.ready));
		sent++;
	endtask

	// pattern request, keeps the local pattern copy in step
	task automatic append_symbol(logic start, logic [SYM_W-1:0] sym);
		if (start)
			copy_len = 0;
		if (copy_len < MAX_PATTERN) begin
			pattern_copy[ADDR_W'(copy_len)] = sym;
			copy_len++;
		end
		send_request(OP_PATTERN, start, sym);
	endtask

	// new pattern from a small alphabet, then text mostly built from it
	task automatic run_episode(bit fill, int alpha_n);
		logic [SYM_W-1:0] alphabet [3];
		int plen;
		int tlen;
		int cur;
		int pick;
		int i;
		for (i = 0; i < 3; i++)
			alphabet[i] = SYM_W'($urandom_range(0, 255));
		send_calm = ($urandom_range(0, 3) == 0);
		if (fill)
			plen = MAX_PATTERN;
		else if ($urandom_range(0, 19) < 16)
			plen = $urandom_range(1, 8);
		else
			plen = $urandom_range(9, 40);
		for (i = 0; i < plen; i++)
			append_symbol(i == 0 || (!fill && $urandom_range(0, 29) == 0),
				alphabet[2'($urandom_range(0, alpha_n - 1))]);
		// full store: extra symbols are dropped, then the whole pattern is searched
		if (fill) begin
			repeat ($urandom_range(1, 3))
				append_symbol(1'b0, SYM_W'($urandom_range(0, 255)));
			for (i = 0; i < 300; i++)
				send_request(OP_TEXT, i == 0, pattern_copy[ADDR_W'(i % copy_len)]);
		end
		tlen = $urandom_range(10, 60);
		cur  = 0;
		for (i = 0; i < tlen; i++) begin
			pick = $urandom_range(0, 49);
			if (pick < 30) begin
				send_request(OP_TEXT, 1'b0, pattern_copy[ADDR_W'(cur)]);
				cur = (cur + 1) % copy_len;
			end else if (pick < 40) begin
				send_request(OP_TEXT, 1'b0, alphabet[2'($urandom_range(0, alpha_n - 1))]);
			end else if (pick < 44) begin
				send_request(OP_TEXT, 1'b0, SYM_W'($urandom_range(0, 255)));
			end else if (pick < 47) begin
				send_request(OP_TEXT, 1'b1, pattern_copy[0]);
				cur = (copy_len > 1) ? 1 : 0;
			end else if (pick < 49 && copy_len < MAX_PATTERN) begin
				// pattern grows while a search is under way
				append_symbol(1'b0, alphabet[2'($urandom_range(0, alpha_n - 1))]);
			end else begin
				send_request(OP_TEXT, 1'($urandom_range(0, 1)),
					alphabet[2'($urandom_range(0, alpha_n - 1))]);
			end
		end
	endtask

	// request side: reset, directed requests, random episodes, drain, verdict
	initial begin
		item_if.valid     <= 1'b0;
		item_if.op        <= OP_PATTERN;
		item_if.start_req <= 1'b0;
		item_if.symbol    <= SYM_ZERO;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// text before any pattern, start ignored
		send_request(OP_TEXT, 1'b0, SYM_ZERO);
		send_request(OP_TEXT, 1'b1, SYM_ONES);
		// first pattern symbol without start, then borders of abab
		append_symbol(1'b0, SYM_A);
		append_symbol(1'b0, SYM_B);
		append_symbol(1'b0, SYM_A);
		append_symbol(1'b0, SYM_B);
		// full match and an overlapping one
		send_request(OP_TEXT, 1'b1, SYM_A);
		send_request(OP_TEXT, 1'b0, SYM_B);
		send_request(OP_TEXT, 1'b0, SYM_A);
		send_request(OP_TEXT, 1'b0, SYM_B);
		send_request(OP_TEXT, 1'b0, SYM_A);
		send_request(OP_TEXT, 1'b0, SYM_B);
		send_request(OP_TEXT, 1'b0, SYM_C);
		// grow the pattern in the middle of a partial match
		send_request(OP_TEXT, 1'b0, SYM_A);
		send_request(OP_TEXT, 1'b0, SYM_B);
		send_request(OP_TEXT, 1'b0, SYM_A);
		append_symbol(1'b0, SYM_C);
		send_request(OP_TEXT, 1'b0, SYM_B);
		send_request(OP_TEXT, 1'b0, SYM_C);
		// pattern restart with extreme symbols
		append_symbol(1'b1, SYM_ONES);
		append_symbol(1'b0, SYM_ZERO);
		send_request(OP_TEXT, 1'b0, SYM_ONES);
		send_request(OP_TEXT, 1'b0, SYM_ZERO);
		send_request(OP_TEXT, 1'b1, SYM_ZERO);

		// one store fill with a single symbol, then random episodes
		run_episode(1'b1, 1);
		// a further fill only while it still fits under the request target
		while (sent < TARGET_REQUESTS)
			run_episode($urandom_range(0, 49) == 0 && sent + FILL_ROOM < TARGET_REQUESTS,
				$urandom_range(1, 3));
		item_if.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls with calm stretches
	initial begin
		int gap;
		result_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid && result_if.ready));
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
